FILE: rtl/ohalloc_pkg.sv
// ----------------------------------------------------------------------------
// ohalloc_pkg
// Shared constants and types for the object handle allocator.
// ----------------------------------------------------------------------------
package ohalloc_pkg;

   // table geometry
   localparam int HANDLE_COUNT = 1024;
   localparam int HW           = $clog2(HANDLE_COUNT);

   // request codes
   localparam logic [2:0] REQ_ALLOC   = 3'd0;
   localparam logic [2:0] REQ_READ    = 3'd1;
   localparam logic [2:0] REQ_RESERVE = 3'd2;
   localparam logic [2:0] REQ_MARK    = 3'd3;
   localparam logic [2:0] REQ_REBUILD = 3'd4;
   localparam logic [2:0] REQ_HEAPRST = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_HANDLE = 2'd1;
   localparam logic [1:0] ST_NO_HEAP   = 2'd2;
   localparam logic [1:0] ST_RESERVE   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_HEAP_BASE = 2'd0;
   localparam logic [1:0] CSR_HEAP_SIZE = 2'd1;
   localparam logic [1:0] CSR_FREE_FLAG = 2'd2;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [31:0]   addr;
      logic [31:0]   len;
      logic [31:0]   kind;
      logic [31:0]   mark;
      logic [HW-1:0] next;
      logic          live;
   } entry_type;

endpackage

FILE: rtl/object_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// object_handle_allocator_top
// Handle table with free list and bump heap allocator, one result per request.
// ----------------------------------------------------------------------------
// After reset the table memory is swept once, one entry per cycle, before
// the first request is taken. All entry state (address, size, type, flags,
// link and live mark) sits in one single-port-write memory with a registered
// read. Allocate and mark-live each do one table read and one write-back;
// read does one table read. Reserve and rebuild sweep every handle from the
// top of the table down to 1 with a pipelined read-modify-write. Reset-heap
// requests and rejected read and reserve requests go straight to the result
// stage. One request is in flight at a time; a finished result waits in the
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
module object_handle_allocator_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [10:0] req_handle,
   input  logic [31:0] req_obj_type,
   input  logic [31:0] req_obj_flags,
   input  logic [31:0] req_size_bytes,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_out_handle,
   output logic [31:0] rsp_out_addr,
   output logic [31:0] rsp_out_size,
   output logic [31:0] rsp_out_type,
   output logic [31:0] rsp_out_flags,
   output logic [9:0]  rsp_out_link,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ohalloc_pkg::*;

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_ALLOC      = 4'd2;
   localparam logic [3:0] S_ALLOC_WAIT = 4'd3;
   localparam logic [3:0] S_READ_WAIT  = 4'd4;
   localparam logic [3:0] S_MARK_WAIT  = 4'd5;
   localparam logic [3:0] S_SWEEP      = 4'd6;
   localparam logic [3:0] S_SWEEP_END  = 4'd7;
   localparam logic [3:0] S_DONE       = 4'd8;

   localparam logic [10:0] HCNT11 = 11'(HANDLE_COUNT);
   localparam logic [HW-1:0] TOP_ID = HW'(HANDLE_COUNT - 1);

   // configuration registers
   logic [31:0] heap_base_ff, heap_size_ff, ffv_ff;
   logic [31:0] limit_ff;
   logic [32:0] limit_sum;

   // allocator state
   logic [3:0]    state_ff, state_in;
   logic [31:0]   cursor_ff, cursor_in;
   logic [10:0]   nu_ff, nu_in;
   logic [HW-1:0] free_head_ff, free_head_in;
   logic [10:0]   floor_ff, floor_in;

   // request staging
   logic [10:0]   hnd_ff, hnd_in;
   logic [31:0]   otype_ff, otype_in, oflags_ff, oflags_in;
   logic [32:0]   asz_ff, asz_in;
   logic [33:0]   end_ff, end_in;
   logic [HW-1:0] id_ff, id_in;
   logic          from_list_ff, from_list_in;

   // sweep control
   logic [HW-1:0] ptr_ff, ptr_in;
   logic [HW-1:0] pd_ptr_ff, pd_ptr_in;
   logic          pend_ff, pend_in;
   logic          use_live_ff, use_live_in;
   logic [HW-1:0] head_ff, head_in;

   // staged result
   logic [1:0]    res_status_ff, res_status_in;
   logic [HW-1:0] res_handle_ff, res_handle_in, res_link_ff, res_link_in;
   logic [31:0]   res_addr_ff, res_addr_in, res_size_ff, res_size_in;
   logic [31:0]   res_type_ff, res_type_in, res_flags_ff, res_flags_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic [HW-1:0] rsp_handle_ff, rsp_link_ff;
   logic [31:0]   rsp_addr_ff, rsp_size_ff, rsp_type_ff, rsp_flags_ff;
   logic          rsp_load;

   // table memory
   entry_type     mem [HANDLE_COUNT];
   entry_type     rd_data_ff;
   logic [HW-1:0] rd_addr;
   logic          mem_we;
   logic [HW-1:0] mem_wa;
   entry_type     mem_wd;

   // sweep datapath
   entry_type     sw_wd;
   logic [HW-1:0] sw_head_nx;

   // alloc datapath
   logic [33:0]   alloc_end;
   logic          accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign limit_sum = {1'b0, heap_base_ff} + {1'b0, heap_size_ff};
   assign alloc_end = {2'b00, cursor_ff} + {1'b0, asz_ff};

   // configuration writes and saturated heap limit
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_size_ff <= 32'd65536;
         ffv_ff       <= 32'd1;
         limit_ff     <= 32'd65536;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEAP_BASE: heap_base_ff <= csr_wdata;
               CSR_HEAP_SIZE: heap_size_ff <= csr_wdata;
               CSR_FREE_FLAG: ffv_ff       <= csr_wdata;
               default: ;
            endcase
         end
         limit_ff <= limit_sum[32] ? 32'hFFFF_FFFF : limit_sum[31:0];
      end
   end

   // sweep entry decision
   always_comb begin
      sw_wd      = rd_data_ff;
      sw_head_nx = head_ff;
      if (use_live_ff) sw_wd.live = 1'b0;
      if ({1'b0, pd_ptr_ff} < nu_ff) begin
         if (use_live_ff && rd_data_ff.live) begin
            // live entries are kept
         end else if ({1'b0, pd_ptr_ff} >= floor_ff &&
                      (rd_data_ff.kind != '0 || rd_data_ff.mark == ffv_ff)) begin
            sw_wd.addr = '0;
            sw_wd.len  = '0;
            sw_wd.kind = '0;
            sw_wd.mark = ffv_ff;
            sw_wd.next = head_ff;
            sw_head_nx = pd_ptr_ff;
         end else if (rd_data_ff.kind == '0 && rd_data_ff.mark == '0 &&
                      rd_data_ff.next == '0) begin
            // untouched
         end else begin
            sw_wd.addr = '0;
            sw_wd.len  = '0;
            sw_wd.kind = '0;
            sw_wd.mark = '0;
            sw_wd.next = '0;
         end
      end
   end

   // main control
   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      nu_in         = nu_ff;
      free_head_in  = free_head_ff;
      floor_in      = floor_ff;
      hnd_in        = hnd_ff;
      otype_in      = otype_ff;
      oflags_in     = oflags_ff;
      asz_in        = asz_ff;
      end_in        = end_ff;
      id_in         = id_ff;
      from_list_in  = from_list_ff;
      ptr_in        = ptr_ff;
      pd_ptr_in     = pd_ptr_ff;
      pend_in       = 1'b0;
      use_live_in   = use_live_ff;
      head_in       = head_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_link_in   = res_link_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      res_type_in   = res_type_ff;
      res_flags_in  = res_flags_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = ptr_ff;
            if (ptr_ff == '0) begin
               mem_wd.addr = 32'd1;
               mem_wd.kind = 32'd1;
            end
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == TOP_ID) state_in = S_IDLE;
         end

         S_IDLE: begin
            if (accept) begin
               hnd_in        = req_handle;
               otype_in      = req_obj_type;
               oflags_in     = req_obj_flags;
               asz_in        = ({1'b0, req_size_bytes} + 33'd3) & ~33'd3;
               res_status_in = ST_OK;
               res_handle_in = '0;
               res_link_in   = '0;
               res_addr_in   = '0;
               res_size_in   = '0;
               res_type_in   = '0;
               res_flags_in  = '0;
               state_in      = S_DONE;
               rd_addr       = req_handle[HW-1:0];
               ptr_in        = TOP_ID;
               head_in       = '0;
               case (req_type)
                  REQ_ALLOC: state_in = S_ALLOC;
                  REQ_READ: begin
                     if (req_handle >= HCNT11) res_status_in = ST_NO_HANDLE;
                     else state_in = S_READ_WAIT;
                  end
                  REQ_RESERVE: begin
                     if (req_handle > HCNT11) begin
                        res_status_in = ST_RESERVE;
                     end else begin
                        if (req_handle > floor_ff) floor_in = req_handle;
                        if (req_handle > nu_ff) nu_in = req_handle;
                        use_live_in = 1'b0;
                        state_in    = S_SWEEP;
                     end
                  end
                  REQ_MARK: begin
                     if (req_handle != '0 && req_handle < HCNT11) state_in = S_MARK_WAIT;
                  end
                  REQ_REBUILD: begin
                     use_live_in = 1'b1;
                     state_in    = S_SWEEP;
                  end
                  REQ_HEAPRST: begin
                     cursor_in   = heap_base_ff;
                     mem_we      = 1'b1;
                     mem_wa      = '0;
                     mem_wd.addr = 32'd1;
                     mem_wd.kind = 32'd1;
                  end
                  default: ;
               endcase
            end
         end

         S_ALLOC: begin
            from_list_in = (free_head_ff != '0);
            id_in        = (free_head_ff != '0) ? free_head_ff : nu_ff[HW-1:0];
            end_in       = alloc_end;
            rd_addr      = id_in;
            if (free_head_ff == '0 && nu_ff >= HCNT11) begin
               res_status_in = ST_NO_HANDLE;
               state_in      = S_DONE;
            end else if (alloc_end > {2'b00, limit_ff}) begin
               res_status_in = ST_NO_HEAP;
               state_in      = S_DONE;
            end else begin
               state_in = S_ALLOC_WAIT;
            end
         end

         S_ALLOC_WAIT: begin
            if (from_list_ff) free_head_in = rd_data_ff.next;
            else nu_in = nu_ff + 11'd1;
            mem_we        = 1'b1;
            mem_wa        = id_ff;
            mem_wd.addr   = cursor_ff;
            mem_wd.len    = asz_ff[31:0];
            mem_wd.kind   = otype_ff;
            mem_wd.mark   = oflags_ff;
            mem_wd.next   = '0;
            mem_wd.live   = rd_data_ff.live;
            cursor_in     = end_ff[31:0];
            res_handle_in = id_ff;
            res_addr_in   = cursor_ff;
            res_size_in   = asz_ff[31:0];
            res_type_in   = otype_ff;
            res_flags_in  = oflags_ff;
            state_in      = S_DONE;
         end

         S_READ_WAIT: begin
            res_handle_in = hnd_ff[HW-1:0];
            res_addr_in   = rd_data_ff.addr;
            res_size_in   = rd_data_ff.len;
            res_type_in   = rd_data_ff.kind;
            res_flags_in  = rd_data_ff.mark;
            res_link_in   = rd_data_ff.next;
            state_in      = S_DONE;
         end

         S_MARK_WAIT: begin
            mem_we      = 1'b1;
            mem_wa      = hnd_ff[HW-1:0];
            mem_wd      = rd_data_ff;
            mem_wd.live = 1'b1;
            state_in    = S_DONE;
         end

         S_SWEEP: begin
            // read the next handle while the previous one is written back
            rd_addr   = ptr_ff;
            pend_in   = 1'b1;
            pd_ptr_in = ptr_ff;
            ptr_in    = ptr_ff - 1'b1;
            if (ptr_ff == HW'(1)) state_in = S_SWEEP_END;
            if (pend_ff) begin
               mem_we  = 1'b1;
               mem_wa  = pd_ptr_ff;
               mem_wd  = sw_wd;
               head_in = sw_head_nx;
            end
         end

         S_SWEEP_END: begin
            mem_we       = 1'b1;
            mem_wa       = pd_ptr_ff;
            mem_wd       = sw_wd;
            head_in      = sw_head_nx;
            free_head_in = sw_head_nx;
            state_in     = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         cursor_ff    <= '0;
         nu_ff        <= 11'd1;
         free_head_ff <= '0;
         floor_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         cursor_ff    <= cursor_in;
         nu_ff        <= nu_in;
         free_head_ff <= free_head_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hnd_ff        <= hnd_in;
      otype_ff      <= otype_in;
      oflags_ff     <= oflags_in;
      asz_ff        <= asz_in;
      end_ff        <= end_in;
      id_ff         <= id_in;
      from_list_ff  <= from_list_in;
      pd_ptr_ff     <= pd_ptr_in;
      use_live_ff   <= use_live_in;
      head_ff       <= head_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_link_ff   <= res_link_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      res_type_ff   <= res_type_in;
      res_flags_ff  <= res_flags_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_link_ff   <= res_link_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_size_ff   <= res_size_ff;
         rsp_type_ff   <= res_type_ff;
         rsp_flags_ff  <= res_flags_ff;
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_addr   = rsp_addr_ff;
   assign rsp_out_size   = rsp_size_ff;
   assign rsp_out_type   = rsp_type_ff;
   assign rsp_out_flags  = rsp_flags_ff;
   assign rsp_out_link   = rsp_link_ff;

`ifndef SYNTHESIS
   // one request at a time: no acceptance right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while another is in flight");

   // next unused handle never passes the table size
   a_nu_bound: assert property (@(posedge clock) disable iff (reset)
      nu_ff <= HCNT11)
      else $error("next unused handle out of range");

   // a result is only loaded when the output register is free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending transaction overwritten");
`endif

endmodule
